[hdl/trf_pkg.sv]
// Package: shared types, constants and command codes for tile reassembly with fill.
`default_nettype none
package trf_pkg;
   localparam int MAX_GRID     = 8;
   localparam int MAX_TILE_DIM = 32;
   localparam int CHECKER_SIZE = 32;
   localparam int GRID_BITS    = $clog2(MAX_GRID);
   localparam int DIM_BITS     = $clog2(MAX_TILE_DIM);
   localparam int TILES        = MAX_GRID * MAX_GRID;
   localparam int TILE_BITS    = 2 * GRID_BITS;
   localparam int ADDR_BITS    = TILE_BITS + 2 * DIM_BITS;
   localparam int STORE_DEPTH  = 1 << ADDR_BITS;
   localparam int COUNT_BITS   = 17;
   localparam int SUM_BITS     = 24;
   localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = 17'd65536;
   localparam int QDEPTH       = 2;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_MARK  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_GRID_ROWS   = 3'd0,
      REG_GRID_COLS   = 3'd1,
      REG_TILE_WIDTH  = 3'd2,
      REG_TILE_HEIGHT = 3'd3,
      REG_CHANNELS    = 3'd4,
      REG_FILL_MODE   = 3'd5
   } reg_type;

   typedef enum logic [2:0] {
      FILL_BLACK   = 3'd0,
      FILL_WHITE   = 3'd1,
      FILL_AVERAGE = 3'd2,
      FILL_NEAREST = 3'd3,
      FILL_CHECKER = 3'd4
   } fill_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [2:0] tile_row;
      logic [2:0] tile_col;
      logic [4:0] pixel_row;
      logic [4:0] pixel_col;
      logic       is_available;
      logic [7:0] chan0_in;
      logic [7:0] chan1_in;
      logic [7:0] chan2_in;
      logic [7:0] chan3_in;
   } req_type;

   typedef struct packed {
      logic [7:0] chan0_out;
      logic [7:0] chan1_out;
      logic [7:0] chan2_out;
      logic [7:0] chan3_out;
      logic       was_filled;
   } rsp_type;

   // classified job handed from front to back
   typedef struct packed {
      logic                 is_read;
      logic                 is_load;
      logic                 tile_valid;
      logic [GRID_BITS-1:0] trow;
      logic [GRID_BITS-1:0] tcol;
      logic [DIM_BITS-1:0]  prow;
      logic [DIM_BITS-1:0]  pcol;
      logic [31:0]          word;
   } job_type;

   // effective configuration
   typedef struct packed {
      logic [GRID_BITS:0] rows;
      logic [GRID_BITS:0] cols;
      logic [DIM_BITS:0]  tw;
      logic [DIM_BITS:0]  th;
      logic [2:0]         nch;
      logic [2:0]         mode;
   } cfg_type;
endpackage
`default_nettype wire

[hdl/tile_reassembly_with_fill.sv]
// Top level: tile reassembly with fill, configuration registers, front and back ends.
// Usage:
//  - req channel (valid/ready) carries load, mark, read and clear transactions.
//  - rsp channel (valid/ready) returns one pixel per in-range read transaction.
//  - csr port writes grid size, tile size, channel count and fill mode; write only
//    while no transaction is outstanding.
//  - Load, mark and clear take effect at acceptance; a load is then written to the
//    64K x 32 pixel store by the back end. These are accepted one per cycle while the
//    queue has room and no read is in flight.
//  - A read result passes through the job queue, dispatch, a bit-serial divider for
//    the four channel averages, then store read and the output register. The
//    nearest-tile fill adds a scan of the availability map after the divider.
//  - While a read is in flight the input is held, so the map and statistics stay as
//    they were at its acceptance; the next transaction is accepted at the earliest in
//    the cycle after the result is registered.
//  - The output register holds a result while the receiver stalls; a following read
//    waits in its output state until that result is taken, and the input stays held.
//  - Synchronous reset clears the map, sums and count and sets the configuration to
//    its defaults; the pixel store is not cleared and no clearing pass is run.
`default_nettype none
module tile_reassembly_with_fill import trf_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   input  wire logic       csr_we,
   input  wire logic [2:0] csr_index,
   input  wire logic [5:0] csr_wdata
);
   logic [3:0] rows_ff, cols_ff;
   logic [5:0] tw_ff, th_ff;
   logic [2:0] nch_ff, mode_ff;
   cfg_type    cfg;
   logic       job_valid, job_ready;
   job_type    job;
   logic       read_done;
   logic [TILES-1:0] map;
   logic [SUM_BITS-1:0]   sums [4];
   logic [COUNT_BITS-1:0] count;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 4'd1; cols_ff <= 4'd1; tw_ff <= 6'd32; th_ff <= 6'd32;
         nch_ff <= 3'd3; mode_ff <= FILL_BLACK;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_GRID_ROWS:   rows_ff <= csr_wdata[3:0];
            REG_GRID_COLS:   cols_ff <= csr_wdata[3:0];
            REG_TILE_WIDTH:  tw_ff   <= csr_wdata;
            REG_TILE_HEIGHT: th_ff   <= csr_wdata;
            REG_CHANNELS:    nch_ff  <= csr_wdata[2:0];
            REG_FILL_MODE:   mode_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.rows = (rows_ff > 4'(MAX_GRID)) ? 4'(MAX_GRID) : rows_ff;
      cfg.cols = (cols_ff > 4'(MAX_GRID)) ? 4'(MAX_GRID) : cols_ff;
      cfg.tw   = (tw_ff > 6'(MAX_TILE_DIM)) ? 6'(MAX_TILE_DIM) : tw_ff;
      cfg.th   = (th_ff > 6'(MAX_TILE_DIM)) ? 6'(MAX_TILE_DIM) : th_ff;
      cfg.nch  = (nch_ff == 3'd0) ? 3'd1 : ((nch_ff > 3'd4) ? 3'd4 : nch_ff);
      cfg.mode = (mode_ff > FILL_CHECKER) ? FILL_BLACK : mode_ff;
   end

   trf_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data, .cfg,
      .job_valid, .job_ready, .job, .read_done, .map, .sum_ff(sums), .count_ff(count)
   );

   trf_back u_back (
      .clock, .reset, .cfg, .job_valid, .job_ready, .job, .map,
      .sum_ff(sums), .count_ff(count), .read_done, .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule
`default_nettype wire

[hdl/trf_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module trf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

[hdl/trf_front.sv]
// Front end: accepts transactions, checks ranges, keeps map and statistics, queues jobs.
`default_nettype none
module trf_front import trf_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   input  wire cfg_type    cfg,
   output logic            job_valid,
   input  wire logic       job_ready,
   output job_type         job,
   input  wire logic       read_done,
   output logic [TILES-1:0]              map,
   output logic [SUM_BITS-1:0]           sum_ff [4],
   output logic [COUNT_BITS-1:0]         count_ff
);
   job_type q_ff [QDEPTH];
   logic [$clog2(QDEPTH)-1:0] wp_ff, rp_ff;
   logic [$clog2(QDEPTH):0]   fill_ff;
   logic [TILES-1:0]          map_ff;
   logic                      hold_ff;
   logic tile_ok, pix_ok, push, pop;
   logic [TILE_BITS-1:0] tidx;
   job_type j;

   assign tidx    = {req_data.tile_row, req_data.tile_col};
   assign tile_ok = ({1'b0, req_data.tile_row} < cfg.rows) && ({1'b0, req_data.tile_col} < cfg.cols);
   assign pix_ok  = tile_ok && ({1'b0, req_data.pixel_row} < cfg.th)
                    && ({1'b0, req_data.pixel_col} < cfg.tw);
   assign req_ready = (fill_ff != QDEPTH[$clog2(QDEPTH):0]) && !hold_ff;
   assign push = req_valid && req_ready && pix_ok
                 && (req_data.cmd == CMD_LOAD || req_data.cmd == CMD_READ);
   assign pop  = job_valid && job_ready;
   assign job_valid = (fill_ff != '0);
   assign job = q_ff[rp_ff];
   assign map = map_ff;

   always_comb begin
      j.is_read    = (req_data.cmd == CMD_READ);
      j.is_load    = (req_data.cmd == CMD_LOAD);
      j.tile_valid = map_ff[tidx];
      j.trow       = req_data.tile_row;
      j.tcol       = req_data.tile_col;
      j.prow       = req_data.pixel_row;
      j.pcol       = req_data.pixel_col;
      j.word       = {req_data.chan3_in, req_data.chan2_in, req_data.chan1_in, req_data.chan0_in};
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= j;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; fill_ff <= '0; map_ff <= '0; count_ff <= '0;
         hold_ff <= 1'b0;
         for (int c = 0; c < 4; c++) sum_ff[c] <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         fill_ff <= fill_ff + {{$clog2(QDEPTH){1'b0}}, push} - {{$clog2(QDEPTH){1'b0}}, pop};
         // hold input while a read uses the map and statistics
         if (push && j.is_read) hold_ff <= 1'b1;
         else if (read_done) hold_ff <= 1'b0;
         if (req_valid && req_ready) begin
            unique case (req_data.cmd)
               CMD_CLEAR: begin
                  map_ff <= '0; count_ff <= '0;
                  for (int c = 0; c < 4; c++) sum_ff[c] <= '0;
               end
               CMD_MARK: if (tile_ok) map_ff[tidx] <= req_data.is_available;
               CMD_LOAD: if (pix_ok && count_ff < COUNT_LIMIT) begin
                  count_ff <= count_ff + 1'b1;
                  for (int c = 0; c < 4; c++)
                     sum_ff[c] <= sum_ff[c] + {{(SUM_BITS-8){1'b0}}, j.word[8*c +: 8]};
               end
               default: ;
            endcase
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) fill_ff <= QDEPTH)
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset) push |=> job_valid)
      else $error("pushed job lost");
   assert property (@(posedge clock) disable iff (reset) count_ff <= COUNT_LIMIT)
      else $error("count beyond limit");
endmodule
`default_nettype wire

[hdl/trf_back.sv]
// Back end: executes load and read jobs, nearest-tile scan, average divider, output register.
`default_nettype none
module trf_back import trf_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              job_valid,
   output logic                   job_ready,
   input  wire job_type           job,
   input  wire logic [TILES-1:0]  map,
   input  wire logic [SUM_BITS-1:0]   sum_ff [4],
   input  wire logic [COUNT_BITS-1:0] count_ff,
   output logic                   read_done,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data
);
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_DIV  = 6'b000100,
      ST_RD   = 6'b001000,
      ST_WAIT = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   job_type   job_ff;
   logic [TILE_BITS-1:0] scan_ff;
   logic                 found_ff;
   logic [7:0]           best_ff;
   logic [TILE_BITS-1:0] bidx_ff;
   logic [1:0]           ch_ff;
   logic [4:0]           bit_ff;
   logic [COUNT_BITS-1:0] rem_ff;
   logic [SUM_BITS-1:0]   num_ff;
   logic [7:0]            quo_ff;
   logic [7:0]            avg_ff [4];
   logic                  from_store_ff;
   rsp_type               out_ff;
   logic [31:0]           px;

   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_addr;
   logic [31:0]           ram_q;

   logic [GRID_BITS-1:0] sy, sx, dy, dx;
   logic [7:0]           d;
   logic                 sv;
   logic [COUNT_BITS:0]  trial;
   logic [SUM_BITS-1:0]  num_sh;
   logic [COUNT_BITS-1:0] rem_sh;
   logic [GRID_BITS+DIM_BITS:0] gx, gy;
   logic chk;

   assign {sy, sx} = scan_ff;
   assign dy = (sy > job_ff.trow) ? sy - job_ff.trow : job_ff.trow - sy;
   assign dx = (sx > job_ff.tcol) ? sx - job_ff.tcol : job_ff.tcol - sx;
   assign d  = 8'(dy * dy) + 8'(dx * dx);
   assign sv = map[scan_ff] && ({1'b0, sy} < cfg.rows) && ({1'b0, sx} < cfg.cols);

   assign rem_sh = {rem_ff[COUNT_BITS-2:0], num_ff[SUM_BITS-1]};
   assign num_sh = {num_ff[SUM_BITS-2:0], 1'b0};
   assign trial  = {1'b0, rem_sh} - {1'b0, count_ff};

   assign gx = (GRID_BITS+DIM_BITS+1)'(job_ff.tcol * cfg.tw) + (GRID_BITS+DIM_BITS+1)'(job_ff.pcol);
   assign gy = (GRID_BITS+DIM_BITS+1)'(job_ff.trow * cfg.th) + (GRID_BITS+DIM_BITS+1)'(job_ff.prow);
   assign chk = gx[$clog2(CHECKER_SIZE)] ^ gy[$clog2(CHECKER_SIZE)];

   assign job_ready = (state_ff == ST_IDLE);
   assign ram_we = (state_ff == ST_IDLE) && job_valid && job.is_load;
   assign read_done = (state_ff == ST_OUT) && (!rsp_valid || rsp_ready);

   always_comb begin
      if (state_ff == ST_IDLE)
         ram_addr = {job.trow, job.tcol, job.prow, job.pcol};
      else if (from_store_ff)
         ram_addr = {job_ff.trow, job_ff.tcol, job_ff.prow, job_ff.pcol};
      else
         ram_addr = {bidx_ff, cfg.th[DIM_BITS:1], cfg.tw[DIM_BITS:1]};
   end

   trf_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data(job.word), .rd_data(ram_q)
   );

   always_comb begin
      px = '0;
      if (from_store_ff) px = ram_q;
      else unique case (cfg.mode)
         FILL_WHITE:   px = '1;
         FILL_AVERAGE: px = {avg_ff[3], avg_ff[2], avg_ff[1], avg_ff[0]};
         FILL_NEAREST: px = found_ff ? ram_q : {avg_ff[3], avg_ff[2], avg_ff[1], avg_ff[0]};
         FILL_CHECKER: px = {8'hFF, {3{chk ? 8'hFF : 8'h00}}};
         default:      px = {8'hFF, 24'h0};
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (job_valid && job.is_read) state_in = ST_DIV;
         ST_DIV:  if (bit_ff == 5'd0 && ch_ff == 2'd3)
                     state_in = (from_store_ff || cfg.mode != FILL_NEAREST) ? ST_RD : ST_SCAN;
         ST_SCAN: if (scan_ff == '1) state_in = ST_RD;
         ST_RD:   state_in = ST_WAIT;
         ST_WAIT: state_in = ST_OUT;
         ST_OUT:  if (!rsp_valid || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && job_valid) begin
         job_ff        <= job;
         from_store_ff <= job.tile_valid;
         ch_ff <= '0; bit_ff <= 5'(SUM_BITS - 1);
         rem_ff <= '0; num_ff <= sum_ff[0]; quo_ff <= '0;
         scan_ff <= '0; found_ff <= 1'b0; best_ff <= '0; bidx_ff <= '0;
      end
      if (state_ff == ST_DIV) begin
         if (count_ff == '0) begin
            if (bit_ff == 5'd0) avg_ff[ch_ff] <= (ch_ff == 2'd3 && cfg.nch == 3'd4) ? 8'd255 : 8'd128;
         end else begin
            if (trial[COUNT_BITS]) rem_ff <= rem_sh;
            else rem_ff <= trial[COUNT_BITS-1:0];
            if (bit_ff == 5'd0) avg_ff[ch_ff] <= {quo_ff[6:0], ~trial[COUNT_BITS]};
         end
         num_ff <= num_sh;
         quo_ff <= {quo_ff[6:0], ~trial[COUNT_BITS]};
         if (bit_ff == 5'd0) begin
            bit_ff <= 5'(SUM_BITS - 1);
            ch_ff  <= ch_ff + 1'b1;
            rem_ff <= '0;
            quo_ff <= '0;
            num_ff <= sum_ff[2'(ch_ff + 1'b1)];
         end else bit_ff <= bit_ff - 1'b1;
      end
      if (state_ff == ST_SCAN) begin
         if (sv && (!found_ff || d < best_ff)) begin
            found_ff <= 1'b1; best_ff <= d; bidx_ff <= scan_ff;
         end
         scan_ff <= scan_ff + 1'b1;
      end
      if (state_ff == ST_OUT && (!rsp_valid || rsp_ready)) begin
         out_ff.chan0_out  <= px[7:0];
         out_ff.chan1_out  <= (cfg.nch > 3'd1) ? px[15:8]  : 8'd0;
         out_ff.chan2_out  <= (cfg.nch > 3'd2) ? px[23:16] : 8'd0;
         out_ff.chan3_out  <= (cfg.nch > 3'd3) ? px[31:24] : 8'd0;
         out_ff.was_filled <= ~from_store_ff;
      end
      if (reset) begin
         state_ff  <= ST_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT && (!rsp_valid || rsp_ready)) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
   end
   assign rsp_data = out_ff;

   assert property (@(posedge clock) disable iff (reset) $onehot(state_ff) || state_ff == ST_IDLE)
      else $error("state corrupt");
   assert property (@(posedge clock) disable iff (reset) (state_ff == ST_RD) |=> state_ff == ST_WAIT)
      else $error("read sequence broken");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid) else $error("result dropped");
endmodule
`default_nettype wire
